>>> src/flic_pkg.sv
// Shared constants and types for the animation chunk decoder.
// No dependencies; imported by flic_rle_chunk_decoder_unit and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package flic_pkg;
    localparam int LINE_PIXELS  = 320;
    localparam int FRAME_PIXELS = 64000;
    localparam int MAP_ENTRIES  = 256;
    localparam int ADDR_W       = 17;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_MAP   = 2'd2;

    localparam logic [1:0] FMT_BYTE_RUN   = 2'd0;
    localparam logic [1:0] FMT_LINE_DELTA = 2'd1;
    localparam logic [1:0] FMT_WORD_DELTA = 2'd2;
    localparam logic [1:0] FMT_UNKNOWN    = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE, PH_H0_LO, PH_H0_HI, PH_H1_LO, PH_H1_HI, PH_LINE_HEAD,
        PH_WLINE_LO, PH_WLINE_HI, PH_SKIP, PH_COUNT, PH_PIX_A, PH_PIX_B
    } t_phase;
endpackage
`default_nettype wire

>>> src/flic_rle_chunk_decoder_unit.sv
// Animation chunk decoder: byte-run, line-delta and word-delta chunks with remap.
// Depends on flic_pkg.
//
// Input channel (i_in_valid / o_in_ready) carries one beat per chunk byte,
// chunk start or remap-table write. Output channel (o_out_valid / i_out_ready)
// carries frame-buffer write runs and the chunk-done marker; a beat causes
// zero or one output beat.
// The remap memory is read into the input register at the edge that accepts a
// beat, and the parser loads the result register from the input register at the
// edge on which it advances, so each result passes through both registers.
// Throughput: one input beat per cycle while the receiver takes results; the
// parser advances once per byte.
// When the receiver stalls, the result register holds and the input register
// fills, after which o_in_ready drops until the result is taken.
// Reset (synchronous, active low) leaves the parser idle, the remap table as
// identity (per-entry valid bits, so no clearing pass) and frame_lines at 200.
// i_cfg_we writes frame_lines at once; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module flic_rle_chunk_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [1:0]  i_chunk_format,
    input  wire logic [7:0]  i_map_index,
    input  wire logic [7:0]  i_map_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_write_address,
    output logic [7:0]       o_pixel_first,
    output logic [7:0]       o_pixel_second,
    output logic [7:0]       o_run_length,
    output logic             o_pair_mode,
    output logic             o_chunk_done,
    output logic             o_unknown_chunk
);
    import flic_pkg::*;

    localparam logic [ADDR_W-1:0] FRAME_END = ADDR_W'(FRAME_PIXELS);

    logic [7:0] r_frame_lines;
    logic [7:0] r_map_mem [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] r_map_vld;

    // Input register.
    logic       r_s1_valid;
    logic [1:0] r_s1_kind;
    logic [7:0] r_s1_byte;
    logic [1:0] r_s1_fmt;
    logic [7:0] r_s1_raw;
    logic       r_s1_hit;
    logic       in_acc, adv;

    // Parser state.
    t_phase            r_phase, n_phase;
    logic [15:0]       r_cur_line, n_cur_line;
    logic [15:0]       r_lines_left, n_lines_left;
    logic [15:0]       r_packets_left, n_packets_left;
    logic [ADDR_W-1:0] r_pixel_address, n_pixel_address;
    logic [7:0]        r_count_left, n_count_left;
    logic [7:0]        r_low_hold, n_low_hold;
    logic [7:0]        r_held_pixel, n_held_pixel;
    logic              r_literal, n_literal;
    logic [1:0]        r_fmt, n_fmt;

    // Result register.
    logic              r_out_valid;
    logic [15:0]       r_wr_addr;
    logic [7:0]        r_wr_p1, r_wr_p2, r_wr_len;
    logic              r_wr_pair, r_done, r_unk;

    // Parser combinational signals.
    logic [7:0]        b, p, neg_b;
    logic [15:0]       w;
    logic              done, unk, wr_go;
    logic              do_begin, do_pkt, do_line, do_add;
    logic [15:0]       begin_pk;
    t_phase            begin_ph;
    logic [8:0]        add_len;
    logic              em_go, em_pair;
    logic [7:0]        em_p1, em_p2;
    logic [ADDR_W-1:0] room, run_n, sum;
    logic [7:0]        wr_len;
    logic [24:0]       line_prod;
    logic [16:0]       skip_sum;

    assign adv        = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_lines <= 8'd200;
        end else if (i_cfg_we) begin
            r_frame_lines <= i_cfg_wdata;
        end
    end

    // Remap memory: write by remap beats, read at the data byte on accept.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_kind == KIND_MAP) begin
            r_map_mem[i_map_index] <= i_map_value;
        end
        if (in_acc) begin
            r_s1_raw <= r_map_mem[i_data_byte];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_s1_hit  <= 1'b0;
        end else if (in_acc) begin
            r_s1_hit <= r_map_vld[i_data_byte];
            if (i_kind == KIND_MAP) begin
                r_map_vld[i_map_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind <= i_kind;
            r_s1_byte <= i_data_byte;
            r_s1_fmt  <= i_chunk_format;
        end
    end

    assign b         = r_s1_byte;
    assign p         = r_s1_hit ? r_s1_raw : r_s1_byte;
    assign w         = {b, r_low_hold};
    assign neg_b     = 8'(~b + 8'd1);
    assign line_prod = 25'(r_cur_line) * 25'(LINE_PIXELS);
    assign skip_sum  = 17'(r_cur_line) + 17'(16'(~w + 16'd1));

    always_comb begin
        n_phase         = r_phase;
        n_cur_line      = r_cur_line;
        n_lines_left    = r_lines_left;
        n_packets_left  = r_packets_left;
        n_count_left    = r_count_left;
        n_low_hold      = r_low_hold;
        n_held_pixel    = r_held_pixel;
        n_literal       = r_literal;
        n_fmt           = r_fmt;
        done            = 1'b0;
        unk             = 1'b0;
        do_begin        = 1'b0;
        do_pkt          = 1'b0;
        do_line         = 1'b0;
        do_add          = 1'b0;
        begin_pk        = 16'd0;
        begin_ph        = PH_SKIP;
        add_len         = 9'd0;
        em_go           = 1'b0;
        em_pair         = 1'b0;
        em_p1           = p;
        em_p2           = p;

        if (r_s1_kind == KIND_START) begin
            n_fmt          = r_s1_fmt;
            n_cur_line     = 16'd0;
            n_lines_left   = 16'd0;
            n_packets_left = 16'd0;
            n_count_left   = 8'd0;
            n_low_hold     = 8'd0;
            n_held_pixel   = 8'd0;
            n_literal      = 1'b0;
            n_phase        = PH_IDLE;
            if (r_s1_fmt == FMT_BYTE_RUN) begin
                n_lines_left = 16'(r_frame_lines);
                if (r_frame_lines == 8'd0) begin
                    done = 1'b1;
                end else begin
                    n_phase = PH_LINE_HEAD;
                end
            end else if (r_s1_fmt == FMT_UNKNOWN) begin
                unk  = 1'b1;
                done = 1'b1;
            end else begin
                n_phase = PH_H0_LO;
            end
        end else if (r_s1_kind == KIND_DATA) begin
            case (r_phase)
                PH_H0_LO, PH_H1_LO, PH_WLINE_LO: begin
                    n_low_hold = b;
                    n_phase    = t_phase'(r_phase + 4'd1);
                end
                PH_H0_HI: begin
                    if (r_fmt == FMT_LINE_DELTA) begin
                        n_cur_line = w;
                        n_phase    = PH_H1_LO;
                    end else begin
                        n_lines_left = w;
                        n_cur_line   = 16'd0;
                        if (w == 16'd0) begin
                            done    = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_WLINE_LO;
                        end
                    end
                end
                PH_H1_HI: begin
                    n_lines_left = w;
                    if (w == 16'd0) begin
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_LINE_HEAD;
                    end
                end
                PH_LINE_HEAD: begin
                    do_begin = 1'b1;
                    begin_pk = 16'(b);
                    begin_ph = (r_fmt == FMT_BYTE_RUN) ? PH_COUNT : PH_SKIP;
                end
                PH_WLINE_HI: begin
                    if (w[15]) begin
                        // Line skips accumulate.
                        n_cur_line = skip_sum[16] ? 16'hFFFF : skip_sum[15:0];
                        n_phase    = PH_WLINE_LO;
                    end else begin
                        do_begin = 1'b1;
                        begin_pk = w;
                        begin_ph = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    do_add  = 1'b1;
                    add_len = 9'(b);
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (r_fmt == FMT_BYTE_RUN) begin
                        n_literal    = b[7];
                        n_count_left = b[7] ? neg_b : b;
                        n_phase      = PH_PIX_A;
                    end else if (!b[7]) begin
                        n_literal    = 1'b1;
                        n_count_left = b;
                        if (b == 8'd0) begin
                            do_pkt = 1'b1;
                        end else begin
                            n_phase = PH_PIX_A;
                        end
                    end else begin
                        n_literal    = 1'b0;
                        n_count_left = neg_b;
                        n_phase      = PH_PIX_A;
                    end
                end
                PH_PIX_A: begin
                    if (r_fmt == FMT_WORD_DELTA) begin
                        n_held_pixel = p;
                        n_phase      = PH_PIX_B;
                    end else if (r_literal) begin
                        em_go   = 1'b1;
                        add_len = 9'd1;
                        if (r_count_left <= 8'd1) begin
                            do_pkt = 1'b1;
                        end else begin
                            n_count_left = r_count_left - 8'd1;
                        end
                    end else begin
                        em_go   = 1'b1;
                        add_len = 9'(r_count_left);
                        do_pkt  = 1'b1;
                    end
                end
                PH_PIX_B: begin
                    em_go   = 1'b1;
                    em_pair = 1'b1;
                    em_p1   = r_held_pixel;
                    if (r_literal) begin
                        add_len = 9'd2;
                        if (r_count_left <= 8'd1) begin
                            do_pkt = 1'b1;
                        end else begin
                            n_count_left = r_count_left - 8'd1;
                            n_phase      = PH_PIX_A;
                        end
                    end else begin
                        add_len = {r_count_left, 1'b0};
                        do_pkt  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_begin) begin
            n_packets_left = begin_pk;
            if (begin_pk == 16'd0) begin
                do_line = 1'b1;
            end else begin
                n_phase = begin_ph;
            end
        end
        if (do_pkt) begin
            if (n_packets_left != 16'd0) begin
                n_packets_left = n_packets_left - 16'd1;
            end
            if (n_packets_left == 16'd0) begin
                do_line = 1'b1;
            end else begin
                n_phase = (r_fmt == FMT_BYTE_RUN) ? PH_COUNT : PH_SKIP;
            end
        end
        if (do_line) begin
            if (r_cur_line != 16'hFFFF) begin
                n_cur_line = r_cur_line + 16'd1;
            end
            if (n_lines_left != 16'd0) begin
                n_lines_left = n_lines_left - 16'd1;
            end
            if (n_lines_left == 16'd0) begin
                done    = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                n_phase = (r_fmt == FMT_WORD_DELTA) ? PH_WLINE_LO : PH_LINE_HEAD;
            end
        end
    end

    // Run emission, clipping and address update.
    always_comb begin
        room   = FRAME_END - r_pixel_address;
        run_n  = (ADDR_W'(add_len) < room) ? ADDR_W'(add_len) : room;
        wr_len = (run_n > ADDR_W'(254)) ? 8'd254 : run_n[7:0];
        wr_go  = em_go && (add_len != 9'd0) && (r_pixel_address < FRAME_END);
        sum    = r_pixel_address + ADDR_W'(add_len);
        if (r_s1_kind == KIND_START) begin
            n_pixel_address = '0;
        end else if (do_begin) begin
            n_pixel_address = (line_prod >= 25'(FRAME_PIXELS)) ? FRAME_END
                                                                : ADDR_W'(line_prod);
        end else if (em_go || do_add) begin
            // Address stays below twice the frame size, so the sum cannot wrap.
            n_pixel_address = (sum >= FRAME_END) ? FRAME_END : sum;
        end else begin
            n_pixel_address = r_pixel_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_cur_line      <= 16'd0;
            r_lines_left    <= 16'd0;
            r_packets_left  <= 16'd0;
            r_pixel_address <= '0;
            r_count_left    <= 8'd0;
            r_low_hold      <= 8'd0;
            r_held_pixel    <= 8'd0;
            r_literal       <= 1'b0;
            r_fmt           <= FMT_BYTE_RUN;
        end else if (adv) begin
            r_phase         <= n_phase;
            r_cur_line      <= n_cur_line;
            r_lines_left    <= n_lines_left;
            r_packets_left  <= n_packets_left;
            r_pixel_address <= n_pixel_address;
            r_count_left    <= n_count_left;
            r_low_hold      <= n_low_hold;
            r_held_pixel    <= n_held_pixel;
            r_literal       <= n_literal;
            r_fmt           <= n_fmt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= wr_go || done;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wr_addr <= wr_go ? r_pixel_address[15:0] : 16'd0;
            r_wr_p1   <= wr_go ? em_p1 : 8'd0;
            r_wr_p2   <= wr_go ? em_p2 : 8'd0;
            r_wr_len  <= wr_go ? wr_len : 8'd0;
            r_wr_pair <= wr_go && em_pair;
            r_done    <= done;
            r_unk     <= unk;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_wr_addr;
    assign o_pixel_first   = r_wr_p1;
    assign o_pixel_second  = r_wr_p2;
    assign o_run_length    = r_wr_len;
    assign o_pair_mode     = r_wr_pair;
    assign o_chunk_done    = r_done;
    assign o_unknown_chunk = r_unk;

    a_unknown_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unknown_chunk |-> o_chunk_done && o_run_length == 8'd0)
        else $error("unknown chunk result without done");
    a_write_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_chunk_done |-> o_run_length != 8'd0)
        else $error("result carries neither a write nor done");
    a_single_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pair_mode |-> o_pixel_second == o_pixel_first)
        else $error("second pixel differs outside pair mode");
    a_addr_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pixel_address <= FRAME_END)
        else $error("pixel address beyond frame end");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_write_address))
        else $error("result lost under stall");
endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for flic_rle_chunk_decoder_unit.
// Depends on flic_pkg and the decoder RTL; a scoreboard class predicts each run.
`timescale 1ns / 1ps
module testbench;
    import flic_pkg::*;

    typedef struct packed {
        bit [15:0] addr;
        bit [7:0]  pix_a;
        bit [7:0]  pix_b;
        bit [7:0]  len;
        bit        pair;
        bit        done;
        bit        unk;
    } t_run;

    class chunk_scoreboard;
        bit [7:0]  frame_lines;
        bit [7:0]  remap [MAP_ENTRIES];
        t_phase    phase;
        bit [15:0] cur_line;
        bit [15:0] lines_left;
        bit [15:0] packets_left;
        int        pix_addr;
        bit [7:0]  count_left;
        bit [7:0]  low_hold;
        bit [7:0]  held_pix;
        bit        literal;
        bit [1:0]  fmt;
        t_run      pending_runs[$];
        t_run      cur;
        bit        wr_valid;
        bit        done_flag;
        int        beats;
        int        runs_seen;
        int        dones_seen;
        int        errors;

        function new();
            frame_lines = 8'd200;
            for (int i = 0; i < MAP_ENTRIES; i++) remap[i] = i[7:0];
            phase = PH_IDLE;
            clear_chunk();
            fmt = FMT_BYTE_RUN;
        endfunction

        function void clear_chunk();
            cur_line = 0; lines_left = 0; packets_left = 0; pix_addr = 0;
            count_left = 0; low_hold = 0; held_pix = 0; literal = 0;
        endfunction

        function void addr_add(int n);
            pix_addr = (pix_addr + n >= FRAME_PIXELS) ? FRAME_PIXELS : pix_addr + n;
        endfunction

        function void emit(int len, bit [7:0] p1, bit [7:0] p2, bit pr);
            int room;
            int n;
            if (len > 0 && pix_addr < FRAME_PIXELS) begin
                room = FRAME_PIXELS - pix_addr;
                n = (len < room) ? len : room;
                wr_valid = 1;
                cur.addr = pix_addr[15:0];
                cur.len = (n > 254) ? 8'd254 : n[7:0];
                cur.pix_a = p1;
                cur.pix_b = p2;
                cur.pair = pr;
            end
            addr_add(len);
        endfunction

        function void line_done();
            if (cur_line != 16'hFFFF) cur_line++;
            if (lines_left > 0) lines_left--;
            if (lines_left == 0) begin
                done_flag = 1;
                phase = PH_IDLE;
            end else begin
                phase = (fmt == FMT_WORD_DELTA) ? PH_WLINE_LO : PH_LINE_HEAD;
            end
        endfunction

        function void packet_done();
            if (packets_left > 0) packets_left--;
            if (packets_left == 0) line_done();
            else phase = (fmt == FMT_BYTE_RUN) ? PH_COUNT : PH_SKIP;
        endfunction

        function void begin_line(bit [15:0] pk, t_phase first);
            int a;
            packets_left = pk;
            a = cur_line * LINE_PIXELS;
            pix_addr = (a >= FRAME_PIXELS) ? FRAME_PIXELS : a;
            if (pk == 0) line_done();
            else phase = first;
        endfunction

        function void take_byte(bit [7:0] b);
            bit [15:0] w;
            bit [7:0]  p;
            int        s;
            w = {b, low_hold};
            p = remap[b];
            case (phase)
                PH_H0_LO, PH_H1_LO, PH_WLINE_LO: begin
                    low_hold = b;
                    phase = t_phase'(int'(phase) + 1);
                end
                PH_H0_HI: begin
                    if (fmt == FMT_LINE_DELTA) begin
                        cur_line = w;
                        phase = PH_H1_LO;
                    end else begin
                        lines_left = w;
                        cur_line = 0;
                        if (w == 0) begin
                            done_flag = 1;
                            phase = PH_IDLE;
                        end else phase = PH_WLINE_LO;
                    end
                end
                PH_H1_HI: begin
                    lines_left = w;
                    if (w == 0) begin
                        done_flag = 1;
                        phase = PH_IDLE;
                    end else phase = PH_LINE_HEAD;
                end
                PH_LINE_HEAD: begin_line({8'd0, b}, (fmt == FMT_BYTE_RUN) ? PH_COUNT : PH_SKIP);
                PH_WLINE_HI: begin
                    // Negative words skip lines; consecutive skips accumulate.
                    if (w[15]) begin
                        s = cur_line + (65536 - w);
                        cur_line = (s > 65535) ? 16'hFFFF : s[15:0];
                        phase = PH_WLINE_LO;
                    end else begin_line(w, PH_SKIP);
                end
                PH_SKIP: begin
                    addr_add(b);
                    phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (fmt == FMT_BYTE_RUN) begin
                        literal = b[7];
                        count_left = b[7] ? 8'(256 - b) : b;
                        phase = PH_PIX_A;
                    end else if (!b[7]) begin
                        literal = 1;
                        count_left = b;
                        if (b == 0) packet_done();
                        else phase = PH_PIX_A;
                    end else begin
                        literal = 0;
                        count_left = 8'(256 - b);
                        phase = PH_PIX_A;
                    end
                end
                PH_PIX_A: begin
                    if (fmt == FMT_WORD_DELTA) begin
                        held_pix = p;
                        phase = PH_PIX_B;
                    end else if (literal) begin
                        emit(1, p, p, 0);
                        if (count_left <= 1) packet_done();
                        else count_left--;
                    end else begin
                        emit(count_left, p, p, 0);
                        packet_done();
                    end
                end
                PH_PIX_B: begin
                    if (literal) begin
                        emit(2, held_pix, p, 1);
                        if (count_left <= 1) packet_done();
                        else begin
                            count_left--;
                            phase = PH_PIX_A;
                        end
                    end else begin
                        emit(2 * count_left, held_pix, p, 1);
                        packet_done();
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_beat(bit [1:0] kind, bit [7:0] b, bit [1:0] f,
                                bit [7:0] mi, bit [7:0] mv);
            beats++;
            cur = '{default: 0};
            wr_valid = 0;
            done_flag = 0;
            if (kind == KIND_MAP) begin
                remap[mi] = mv;
                return;
            end
            if (kind == KIND_START) begin
                fmt = f;
                clear_chunk();
                phase = PH_IDLE;
                if (f == FMT_BYTE_RUN) begin
                    lines_left = {8'd0, frame_lines};
                    if (frame_lines == 0) done_flag = 1;
                    else phase = PH_LINE_HEAD;
                end else if (f == FMT_UNKNOWN) begin
                    cur.unk = 1;
                    done_flag = 1;
                end else phase = PH_H0_LO;
            end else if (kind == KIND_DATA) begin
                take_byte(b);
            end
            if (wr_valid || done_flag) begin
                cur.done = done_flag;
                pending_runs.push_back(cur);
            end
        endfunction

        function void check_result(t_run got);
            t_run exp;
            runs_seen++;
            if (got.done) dones_seen++;
            if (pending_runs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result addr=%0d len=%0d done=%0b",
                         $time, got.addr, got.len, got.done);
                return;
            end
            exp = pending_runs.pop_front();
            if (got != exp) begin
                errors++;
                $display({"%0t: mismatch expected addr=%0d p1=%0h p2=%0h len=%0d",
                          " pair=%0b done=%0b unk=%0b"},
                         $time, exp.addr, exp.pix_a, exp.pix_b, exp.len, exp.pair,
                         exp.done, exp.unk);
                $display({"%0t:          actual   addr=%0d p1=%0h p2=%0h len=%0d",
                          " pair=%0b done=%0b unk=%0b"},
                         $time, got.addr, got.pix_a, got.pix_b, got.len, got.pair,
                         got.done, got.unk);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [7:0]  i_cfg_wdata = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [1:0]  i_kind = KIND_DATA;
    logic [7:0]  i_data_byte = 0;
    logic [1:0]  i_chunk_format = FMT_BYTE_RUN;
    logic [7:0]  i_map_index = 0;
    logic [7:0]  i_map_value = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [15:0] o_write_address;
    logic [7:0]  o_pixel_first;
    logic [7:0]  o_pixel_second;
    logic [7:0]  o_run_length;
    logic        o_pair_mode;
    logic        o_chunk_done;
    logic        o_unknown_chunk;

    chunk_scoreboard sb = new();
    bit calm = 0;
    int cut_left = -1;

    flic_rle_chunk_decoder_unit dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_beat(i_kind, i_data_byte, i_chunk_format, i_map_index, i_map_value);
            if (o_out_valid && i_out_ready)
                sb.check_result('{o_write_address, o_pixel_first, o_pixel_second,
                                  o_run_length, o_pair_mode, o_chunk_done,
                                  o_unknown_chunk});
        end
    end

    task automatic send(bit [1:0] kind, bit [7:0] b, bit [1:0] f, bit [7:0] mi, bit [7:0] mv);
        if (!calm && $urandom_range(99) < 31) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_kind <= kind;
        i_data_byte <= b;
        i_chunk_format <= f;
        i_map_index <= mi;
        i_map_value <= mv;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Chunk bytes stop flowing once a broken sequence has been cut short.
    task automatic put(bit [7:0] b);
        if (cut_left == 0) return;
        if (cut_left > 0) cut_left--;
        if ($urandom_range(99) < 3)
            send(KIND_MAP, 8'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
        send(KIND_DATA, b, 2'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic put_word(bit [15:0] w);
        put(w[7:0]);
        put(w[15:8]);
    endtask

    task automatic start(bit [1:0] f);
        cut_left = ($urandom_range(99) < 12) ? $urandom_range(1, 20) : -1;
        send(KIND_START, 8'($urandom), f, 8'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending_runs.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_lines(bit [7:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.frame_lines = v;
        i_cfg_we <= 0;
    endtask

    function automatic bit [7:0] pick_count(bit lit_high);
        // Byte-run literals and delta repeats use the high half; keep most runs short.
        if ($urandom_range(99) < 5) return lit_high ? 8'h80 : 8'h7F;
        return lit_high ? 8'($urandom_range(250, 255)) : 8'($urandom_range(0, 5));
    endfunction

    task automatic byte_run_chunk();
        bit [7:0] c;
        start(FMT_BYTE_RUN);
        for (int ln = 0; ln < sb.frame_lines && cut_left != 0; ln++) begin
            int npk = (sb.frame_lines > 20 && $urandom_range(9) != 0) ? 0 : $urandom_range(0, 3);
            put(8'(npk));
            for (int k = 0; k < npk; k++) begin
                c = pick_count(1'($urandom_range(1)));
                put(c);
                if (c[7]) for (int j = 0; j < 256 - c; j++) put(8'($urandom));
                else put(8'($urandom));
            end
        end
    endtask

    task automatic delta_packets(int npk, bit pairs);
        bit [7:0] c;
        for (int k = 0; k < npk; k++) begin
            put($urandom_range(99) < 10 ? 8'hFF : 8'($urandom_range(0, 40)));
            c = pick_count(1'($urandom_range(1)));
            put(c);
            if (!c[7]) for (int j = 0; j < (pairs ? 2 : 1) * c; j++) put(8'($urandom));
            else repeat (pairs ? 2 : 1) put(8'($urandom));
        end
    endtask

    task automatic line_delta_chunk();
        int nl = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        start(FMT_LINE_DELTA);
        put_word($urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 205)));
        put_word(16'(nl));
        for (int ln = 0; ln < nl && cut_left != 0; ln++) begin
            int npk = $urandom_range(0, 3);
            put(8'(npk));
            delta_packets(npk, 0);
        end
    endtask

    task automatic word_delta_chunk();
        int nl = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        start(FMT_WORD_DELTA);
        put_word(16'(nl));
        for (int ln = 0; ln < nl && cut_left != 0; ln++) begin
            int npk = $urandom_range(0, 3);
            while ($urandom_range(99) < 30)
                put_word($urandom_range(9) == 0 ? 16'h8000 : 16'(65536 - $urandom_range(1, 60)));
            put_word(16'(npk));
            delta_packets(npk, 1);
        end
    endtask

    task automatic random_phase(bit [7:0] lines, int upto);
        write_lines(lines);
        while (sb.beats < upto) begin
            calm = (sb.beats > 700 && sb.beats < 850);
            case ($urandom_range(9))
                0, 1, 2: byte_run_chunk();
                3, 4, 5: line_delta_chunk();
                6, 7:    word_delta_chunk();
                default: repeat ($urandom_range(1, 6))
                    send(2'($urandom_range(0, 3)), 8'($urandom), 2'($urandom),
                         8'($urandom), 8'($urandom));
            endcase
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        write_lines(2);
        // Directed: remap, unknown format, stray beats, zero runs, long pair repeat.
        send(KIND_MAP, 0, FMT_BYTE_RUN, 8'd5, 8'hAA);
        send(KIND_START, 0, FMT_UNKNOWN, 0, 0);
        send(KIND_DATA, 8'hFF, FMT_UNKNOWN, 8'hFF, 8'hFF);
        send(2'd3, 8'h55, FMT_WORD_DELTA, 8'h55, 8'h55);
        send(KIND_START, 0, FMT_BYTE_RUN, 0, 0);
        put(2); put(0); put(5); put(8'hFF); put(8'hFF);
        put(1); put(8'h7F); put(0);
        send(KIND_START, 0, FMT_WORD_DELTA, 0, 0);
        put_word(1); put_word(16'hFFFE); put_word(1);
        put(0); put(8'h80); put(1); put(2);
        send(KIND_START, 0, FMT_LINE_DELTA, 0, 0);
        put_word(0); put_word(0);
        write_lines(0);
        send(KIND_START, 0, FMT_BYTE_RUN, 0, 0);
        random_phase(3, 300);
        random_phase(255, 600);
        random_phase(1, 900);
        random_phase(200, 1150);
        random_phase(7, 1400);
        drain();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d input beats and %0d results, %0d of them chunk-done markers.",
                 sb.beats, sb.runs_seen, sb.dones_seen);
        if (sb.errors == 0 && sb.pending_runs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout after %0t", $time);
        $display("Verification failed");
        $finish;
    end
endmodule
